// File: rtl/scu_pkg.sv
// shared types, constants and helpers of the stochastic cell update block
// no dependencies; scu_trial, the top level and the testbench use it by scoped names
package scu_pkg;

   // table geometry
   localparam int SPECIES_SLOTS  = 16;
   localparam int HABITAT_SLOTS  = 4;
   localparam int NEIGHBOR_COUNT = 8;
   localparam int TABLE_DEPTH    = SPECIES_SLOTS * HABITAT_SLOTS;
   localparam int ADDR_W         = $clog2(TABLE_DEPTH);

   // field widths
   localparam int SP_W     = 4;
   localparam int HAB_W    = 2;
   localparam int KEY_W    = 16;
   localparam int FRAC_W   = 16;
   localparam int PROB_W   = 17;
   localparam int SUM_W    = PROB_W + $clog2(NEIGHBOR_COUNT);
   localparam int NB_W     = SP_W * NEIGHBOR_COUNT;
   localparam int OUTC_W   = 3;
   localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1 << FRAC_W);

   // request kinds
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_UPDATE = 1'b1;

   // outcome codes
   localparam logic [OUTC_W-1:0] OUT_WRITTEN   = 3'd0;
   localparam logic [OUTC_W-1:0] OUT_COLONIZED = 3'd1;
   localparam logic [OUTC_W-1:0] OUT_EMPTY     = 3'd2;
   localparam logic [OUTC_W-1:0] OUT_DISPLACED = 3'd3;
   localparam logic [OUTC_W-1:0] OUT_DIED      = 3'd4;
   localparam logic [OUTC_W-1:0] OUT_SURVIVED  = 3'd5;

   // one transaction as it moves down the trial pipeline
   typedef struct packed {
      logic                                   valid;
      logic                                   upd;
      logic [SP_W-1:0]                        center;
      logic [NB_W-1:0]                        nb;
      logic [KEY_W-1:0]                       key_ev;
      logic [KEY_W-1:0]                       key_ch;
      logic [KEY_W-1:0]                       key_de;
      logic [PROB_W-1:0]                      death;
      logic [NEIGHBOR_COUNT-1:0][PROB_W-1:0]  w;
      logic [NEIGHBOR_COUNT-1:0][PROB_W-1:0]  om;
      logic [SUM_W-1:0]                       sum;
      logic [PROB_W-1:0]                      none_p;
      logic [SUM_W-1:0]                       t;
      logic [SP_W-1:0]                        winner;
   } pipe_type;

   // table address of a habitat and species pair
   function automatic logic [ADDR_W-1:0] tbl_addr(input logic [HAB_W-1:0] hab,
                                                   input logic [SP_W-1:0] sp);
      int a;
      a = (int'(hab) % HABITAT_SLOTS) * SPECIES_SLOTS + (int'(sp) % SPECIES_SLOTS);
      return ADDR_W'(a);
   endfunction

   // clamp a probability to one
   function automatic logic [PROB_W-1:0] sat_prob(input logic [PROB_W-1:0] v);
      return (v > PROB_ONE) ? PROB_ONE : v;
   endfunction

endpackage

// File: rtl/scu_ram.sv
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
module scu_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, holds its data while not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/scu_trial.sv
// event trial pipeline: chained survival product, one multiply per stage,
// choice threshold and weighted winner search; uses scu_pkg
module scu_trial (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  scu_pkg::pipe_type s_in,
   output scu_pkg::pipe_type s_out
);

   localparam int NB = scu_pkg::NEIGHBOR_COUNT;
   localparam int FW = scu_pkg::FRAC_W;
   localparam int PW = scu_pkg::PROB_W;
   localparam int SW = scu_pkg::SUM_W;
   localparam int KW = scu_pkg::KEY_W;
   localparam int SPW = scu_pkg::SP_W;

   scu_pkg::pipe_type pipe_ff [NB];
   scu_pkg::pipe_type pipe_in [NB];

   // per stage next value
   always_comb begin
      scu_pkg::pipe_type src;
      scu_pkg::pipe_type nxt;
      logic [2*PW-1:0]   prod;
      logic [KW+SW-1:0]  tprod;
      logic [SW-1:0]     cum;
      logic              found;
      for (int k = 0; k < NB; k++) begin
         src = (k == 0) ? s_in : pipe_ff[(k == 0) ? 0 : k-1];
         nxt = src;
         // survival product, truncated
         prod = src.none_p * src.om[k];
         nxt.none_p = prod[FW+PW-1:FW];
         // choice threshold
         if (k == 0) begin
            tprod = src.key_ch * src.sum;
            nxt.t = tprod[FW+SW-1:FW];
         end
         // first neighbor whose running weight sum exceeds the threshold
         if (k == 1) begin
            cum = '0;
            found = 1'b0;
            nxt.winner = src.nb[SPW-1:0];
            for (int i = 0; i < NB; i++) begin
               cum = cum + SW'(src.w[i]);
               if (!found && cum > src.t) begin
                  nxt.winner = src.nb[i*SPW +: SPW];
                  found = 1'b1;
               end
            end
         end
         pipe_in[k] = nxt;
      end
   end

   // stage registers, frozen on stall
   always_ff @(posedge clock) begin
      for (int k = 0; k < NB; k++) begin
         if (reset) begin
            pipe_ff[k].valid <= 1'b0;
         end else if (en) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign s_out = pipe_ff[NB-1];

endmodule

// File: rtl/stochastic_cell_update_top.sv
// top level of the stochastic cell update block: table banks, weight prep,
// trial pipeline and output register; uses scu_pkg, scu_ram, scu_trial
//
// channel  dir  tvalid/tready           payload
// req      in   req_tvalid/req_tready   tuser: req_type; tdata: cell or table entry
// rsp      out  rsp_tvalid/rsp_tready   tdata: next_species, outcome
//
// one transaction per clock while the output is not stalled; a result passes in turn
// the ram read, weight, eight survival product stages (one multiplier each) and output registers.
// reset clears only valid bits; the table is undefined until written.
// a table write lands at its acceptance edge and is seen by the next update.
// a stalled result freezes the whole pipeline, ram read data included.
module stochastic_cell_update_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,   // req_type
   // habitat, center_species, neighbor_species, key_event, key_choice,
   // key_death, prob_death, prob_displace, prob_colonize, zero pad
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata    // next_species, outcome, zero pad
);

   localparam int NB  = scu_pkg::NEIGHBOR_COUNT;
   localparam int PW  = scu_pkg::PROB_W;
   localparam int SPW = scu_pkg::SP_W;
   localparam int SW  = scu_pkg::SUM_W;
   localparam int AW  = scu_pkg::ADDR_W;
   localparam int KW  = scu_pkg::KEY_W;

   // input fields
   logic [scu_pkg::HAB_W-1:0] hab;
   logic [SPW-1:0]            center;
   logic [scu_pkg::NB_W-1:0]  nb;
   logic [KW-1:0]             key_ev, key_ch, key_de;
   logic [PW-1:0]             p_death, p_disp, p_col;

   assign hab     = req_tdata[1:0];
   assign center  = req_tdata[5:2];
   assign nb      = req_tdata[37:6];
   assign key_ev  = req_tdata[53:38];
   assign key_ch  = req_tdata[69:54];
   assign key_de  = req_tdata[85:70];
   assign p_death = req_tdata[102:86];
   assign p_disp  = req_tdata[119:103];
   assign p_col   = req_tdata[136:120];

   logic en, acc, wr, rd;
   logic rsp_valid_ff;
   logic [SPW-1:0] rsp_next_ff;
   logic [scu_pkg::OUTC_W-1:0] rsp_outc_ff;

   assign en  = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign acc = req_tvalid && en;
   assign wr  = acc && (req_tuser == scu_pkg::REQ_WRITE);
   assign rd  = acc;

   // table banks, one read port per neighbor and one for the center
   logic [AW-1:0] waddr;
   logic [2*PW-1:0] nb_wdata;
   logic [2*PW-1:0] nb_rdata [NB];
   logic [PW-1:0]   ce_rdata;

   assign waddr    = scu_pkg::tbl_addr(hab, center);
   assign nb_wdata = {scu_pkg::sat_prob(p_col), scu_pkg::sat_prob(p_disp)};

   for (genvar i = 0; i < NB; i++) begin : g_bank
      scu_ram #(.WIDTH(2*PW), .DEPTH(scu_pkg::TABLE_DEPTH)) u_nb_ram (
         .clock (clock),
         .we    (wr),
         .waddr (waddr),
         .wdata (nb_wdata),
         .re    (rd),
         .raddr (scu_pkg::tbl_addr(hab, nb[i*SPW +: SPW])),
         .rdata (nb_rdata[i])
      );
   end

   scu_ram #(.WIDTH(PW), .DEPTH(scu_pkg::TABLE_DEPTH)) u_ce_ram (
      .clock (clock),
      .we    (wr),
      .waddr (waddr),
      .wdata (scu_pkg::sat_prob(p_death)),
      .re    (rd),
      .raddr (waddr),
      .rdata (ce_rdata)
   );

   // request fields aligned with ram read data
   logic           s1_valid_ff, s1_upd_ff;
   logic [SPW-1:0] s1_center_ff;
   logic [scu_pkg::NB_W-1:0] s1_nb_ff;
   logic [KW-1:0]  s1_kev_ff, s1_kch_ff, s1_kde_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_upd_ff    <= req_tuser;
         s1_center_ff <= center;
         s1_nb_ff     <= nb;
         s1_kev_ff    <= key_ev;
         s1_kch_ff    <= key_ch;
         s1_kde_ff    <= key_de;
      end
   end

   // weight column select, complements and weight sum
   scu_pkg::pipe_type s2_in, s2_ff;

   always_comb begin
      logic [SW-1:0] sum;
      sum = '0;
      s2_in        = '0;
      s2_in.valid  = s1_valid_ff;
      s2_in.upd    = s1_upd_ff;
      s2_in.center = s1_center_ff;
      s2_in.nb     = s1_nb_ff;
      s2_in.key_ev = s1_kev_ff;
      s2_in.key_ch = s1_kch_ff;
      s2_in.key_de = s1_kde_ff;
      s2_in.death  = ce_rdata;
      s2_in.none_p = scu_pkg::PROB_ONE;
      for (int i = 0; i < NB; i++) begin
         s2_in.w[i]  = (s1_center_ff == '0) ? nb_rdata[i][2*PW-1:PW] : nb_rdata[i][PW-1:0];
         s2_in.om[i] = scu_pkg::PROB_ONE - s2_in.w[i];
         sum = sum + SW'(s2_in.w[i]);
      end
      s2_in.sum = sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else if (en) begin
         s2_ff <= s2_in;
      end
   end

   // survival product and winner choice
   scu_pkg::pipe_type tr_out;

   scu_trial u_trial (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .s_in  (s2_ff),
      .s_out (tr_out)
   );

   // final decision
   logic [SPW-1:0] next_in;
   logic [scu_pkg::OUTC_W-1:0] outc_in;

   always_comb begin
      logic fire;
      fire = {1'b0, tr_out.key_ev} >= tr_out.none_p;
      if (tr_out.upd == scu_pkg::REQ_WRITE) begin
         next_in = '0;
         outc_in = scu_pkg::OUT_WRITTEN;
      end else if (tr_out.center == '0) begin
         next_in = fire ? tr_out.winner : '0;
         outc_in = fire ? scu_pkg::OUT_COLONIZED : scu_pkg::OUT_EMPTY;
      end else if (fire && tr_out.winner != tr_out.center) begin
         next_in = tr_out.winner;
         outc_in = scu_pkg::OUT_DISPLACED;
      end else if ({1'b0, tr_out.key_de} <= tr_out.death) begin
         next_in = '0;
         outc_in = scu_pkg::OUT_DIED;
      end else begin
         next_in = tr_out.center;
         outc_in = scu_pkg::OUT_SURVIVED;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= tr_out.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_next_ff <= next_in;
         rsp_outc_ff <= outc_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_outc_ff, rsp_next_ff};

   // checks
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready does not follow output stall");

   a_outc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_outc_ff <= scu_pkg::OUT_SURVIVED)
      else $error("outcome code out of range");

   a_empty_next: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_outc_ff == scu_pkg::OUT_WRITTEN ||
                     rsp_outc_ff == scu_pkg::OUT_EMPTY ||
                     rsp_outc_ff == scu_pkg::OUT_DIED) |-> rsp_next_ff == '0)
      else $error("empty outcome with a species");

   a_stall_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(s2_ff) && rsp_tvalid)
      else $error("pipeline moved during stall");

endmodule

// File: tb/tb_stochastic_cell_update_top.sv
// self-checking testbench of stochastic_cell_update_top: table loads, cell updates,
// random idling and back-pressure, each result checked against a local predictor
// depends on scu_pkg and the rtl of stochastic_cell_update_top
`timescale 1ns / 1ps

module tb_stochastic_cell_update_top;

   typedef struct packed {
      logic [scu_pkg::SP_W-1:0]   next_sp;
      logic [scu_pkg::OUTC_W-1:0] outcome;
   } cell_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic         req_tuser;   // req_type
   // habitat, center_species, neighbor_species, key_event, key_choice,
   // key_death, prob_death, prob_displace, prob_colonize, zero pad
   logic [143:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [7:0]   rsp_tdata;   // next_species, outcome, zero pad

   // predictor copy of the probability table
   logic [scu_pkg::PROB_W-1:0] death_tbl [scu_pkg::TABLE_DEPTH];
   logic [scu_pkg::PROB_W-1:0] disp_tbl  [scu_pkg::TABLE_DEPTH];
   logic [scu_pkg::PROB_W-1:0] colon_tbl [scu_pkg::TABLE_DEPTH];

   cell_result_type pending_results[$];
   int errors;
   int n_writes, n_updates, n_checked;
   int outcome_seen[6];
   bit idle_on;
   int hold_left;
   int quiet_cycles;

   stochastic_cell_update_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // pack one request
   function automatic logic [143:0] pack_req(
         input logic [1:0] hab, input logic [3:0] center, input logic [31:0] nb,
         input logic [15:0] ke, input logic [15:0] kc, input logic [15:0] kd,
         input logic [16:0] pd, input logic [16:0] pp, input logic [16:0] pc);
      return {7'd0, pc, pp, pd, kd, kc, ke, nb, center, hab};
   endfunction

   function automatic logic [scu_pkg::PROB_W-1:0] clamp_one(
         input logic [scu_pkg::PROB_W-1:0] v);
      return (v > 17'd65536) ? 17'd65536 : v;
   endfunction

   // colonization or displacement trial over the eight neighbors
   function automatic bit neighbor_trial(input logic [1:0] hab, input logic [31:0] nb,
                                         input bit use_colon, input logic [15:0] ke,
                                         input logic [15:0] kc, output logic [3:0] winner);
      logic [16:0] w [8];
      logic [3:0]  sp [8];
      longint unsigned none_p, sum, t, cum;
      none_p = 64'd65536;
      sum = 0;
      for (int i = 0; i < 8; i++) begin
         sp[i] = nb[4*i +: 4];
         w[i] = use_colon ? colon_tbl[{hab, sp[i]}] : disp_tbl[{hab, sp[i]}];
         none_p = (none_p * (65536 - longint'(w[i]))) >> 16;
         sum += w[i];
      end
      winner = sp[0];
      if (longint'(ke) < none_p) return 1'b0;
      if (sum != 0) begin
         t = (longint'(kc) * sum) >> 16;
         cum = 0;
         for (int i = 0; i < 8; i++) begin
            cum += w[i];
            if (cum > t) begin
               winner = sp[i];
               break;
            end
         end
      end
      return 1'b1;
   endfunction

   // next state of one accepted transaction; table writes update the copy
   function automatic cell_result_type next_cell_state(input logic typ,
                                                       input logic [143:0] d);
      cell_result_type r;
      logic [1:0]  hab;
      logic [3:0]  center, winner;
      logic [31:0] nb;
      logic [15:0] ke, kc, kd;
      hab = d[1:0]; center = d[5:2]; nb = d[37:6];
      ke = d[53:38]; kc = d[69:54]; kd = d[85:70];
      if (typ == scu_pkg::REQ_WRITE) begin
         death_tbl[{hab, center}] = clamp_one(d[102:86]);
         disp_tbl[{hab, center}]  = clamp_one(d[119:103]);
         colon_tbl[{hab, center}] = clamp_one(d[136:120]);
         r.next_sp = '0; r.outcome = scu_pkg::OUT_WRITTEN;
      end else if (center == 0) begin
         if (neighbor_trial(hab, nb, 1'b1, ke, kc, winner)) begin
            r.next_sp = winner; r.outcome = scu_pkg::OUT_COLONIZED;
         end else begin
            r.next_sp = '0; r.outcome = scu_pkg::OUT_EMPTY;
         end
      end else if (neighbor_trial(hab, nb, 1'b0, ke, kc, winner) && winner != center) begin
         r.next_sp = winner; r.outcome = scu_pkg::OUT_DISPLACED;
      end else if (kd <= death_tbl[{hab, center}]) begin
         r.next_sp = '0; r.outcome = scu_pkg::OUT_DIED;
      end else begin
         r.next_sp = center; r.outcome = scu_pkg::OUT_SURVIVED;
      end
      return r;
   endfunction

   // send one transaction, with an optional idle burst before it
   task automatic send_item(input logic typ, input logic [143:0] d);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= typ;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(next_cell_state(typ, d));
      if (typ == scu_pkg::REQ_WRITE) n_writes++; else n_updates++;
   endtask

   task automatic drop_valid();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      drop_valid();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // table write; profile 0 small, 1 full range, 2 extremes
   task automatic write_entry(input logic [1:0] hab, input logic [3:0] sp, input int profile);
      logic [16:0] p [3];
      for (int k = 0; k < 3; k++) begin
         case (profile)
            0: p[k] = 17'($urandom_range(0, 3000));
            1: p[k] = 17'($urandom_range(0, 131071));
            default: begin
               case ($urandom_range(0, 3))
                  0: p[k] = 17'd0;
                  1: p[k] = 17'd65536;
                  2: p[k] = 17'($urandom_range(65537, 131071));
                  default: p[k] = 17'($urandom_range(0, 8000));
               endcase
            end
         endcase
      end
      send_item(scu_pkg::REQ_WRITE, pack_req(hab, sp, $urandom, 16'($urandom),
                                             16'($urandom), 16'($urandom),
                                             p[0], p[1], p[2]));
   endtask

   task automatic load_table(input int profile);
      for (int h = 0; h < scu_pkg::HABITAT_SLOTS; h++)
         for (int s = 0; s < scu_pkg::SPECIES_SLOTS; s++)
            write_entry(h[1:0], s[3:0], profile);
   endtask

   task automatic random_update();
      logic [3:0]  center;
      logic [31:0] nb;
      center = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom);
      nb = $urandom;
      // sparse neighborhoods leave many cells empty or surviving
      if ($urandom_range(0, 2) == 0)
         for (int i = 0; i < 8; i++)
            if ($urandom_range(0, 1)) nb[4*i +: 4] = 4'd0;
      send_item(scu_pkg::REQ_UPDATE,
                pack_req(2'($urandom), center, nb, 16'($urandom), 16'($urandom),
                         16'($urandom), 17'($urandom), 17'($urandom), 17'($urandom)));
   endtask

   // directed: saturation, extreme keys, extreme neighborhoods, empty winner
   task automatic test_directed();
      send_item(scu_pkg::REQ_WRITE, pack_req(2'd3, 4'd15, '1, '1, '1, '1,
                                             17'h1ffff, 17'd65537, 17'd65536));
      send_item(scu_pkg::REQ_WRITE, pack_req(2'd3, 4'd0, 32'h0, 16'h0, 16'h0, 16'h0,
                                             17'd0, 17'd40000, 17'd30000));
      send_item(scu_pkg::REQ_WRITE, pack_req(2'd0, 4'd0, 32'h0, 16'h0, 16'h0, 16'h0,
                                             17'd0, 17'd0, 17'd0));
      send_item(scu_pkg::REQ_WRITE, pack_req(2'd0, 4'd1, 32'h0, 16'h0, 16'h0, 16'h0,
                                             17'd65535, 17'd1, 17'd1));
      for (int k = 0; k < 2; k++) begin
         logic [15:0] key;
         key = k ? 16'hffff : 16'h0000;
         send_item(scu_pkg::REQ_UPDATE, pack_req(2'd3, 4'd0, 32'h0, key, key, key,
                                                 17'd0, 17'd0, 17'd0));
         send_item(scu_pkg::REQ_UPDATE, pack_req(2'd3, 4'd0, 32'hffffffff, key, key, key,
                                                 17'd0, 17'd0, 17'd0));
         send_item(scu_pkg::REQ_UPDATE, pack_req(2'd3, 4'd15, 32'hffffffff, key, key, key,
                                                 17'd0, 17'd0, 17'd0));
         send_item(scu_pkg::REQ_UPDATE, pack_req(2'd3, 4'd15, 32'h0, key, key, key,
                                                 17'd0, 17'd0, 17'd0));
         send_item(scu_pkg::REQ_UPDATE, pack_req(2'd0, 4'd0, 32'h0, key, key, key,
                                                 17'd0, 17'd0, 17'd0));
         send_item(scu_pkg::REQ_UPDATE, pack_req(2'd0, 4'd1, 32'h0, key, key, key,
                                                 17'd0, 17'd0, 17'd0));
         send_item(scu_pkg::REQ_UPDATE, pack_req(2'd0, 4'd1, 32'h11111111, key, key, key,
                                                 17'd0, 17'd0, 17'd0));
         send_item(scu_pkg::REQ_UPDATE, pack_req(2'd3, 4'd0, 32'hf0f0f0f0, key, key, key,
                                                 17'd0, 17'd0, 17'd0));
      end
      wait_drained();
   endtask

   task automatic test_random(input int profile, input int count);
      load_table(profile);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 19) == 0) write_entry(2'($urandom), 4'($urandom), profile);
         else random_update();
      end
   endtask

   // receiver holds off long enough for the pipeline to fill and stall the input
   task automatic test_backpressure();
      hold_left = 80;
      for (int i = 0; i < 60; i++) random_update();
      wait_drained();
   endtask

   // receiver side
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14) - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         cell_result_type got, exp_r;
         got.next_sp = rsp_tdata[3:0];
         got.outcome = rsp_tdata[6:4];
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result next=%0d outcome=%0d",
                     $time, got.next_sp, got.outcome);
            errors++;
         end else begin
            exp_r = pending_results.pop_front();
            n_checked++;
            if (exp_r.outcome < 6) outcome_seen[exp_r.outcome]++;
            if (got.next_sp !== exp_r.next_sp) begin
               $display("%0t: next_species expected %0d actual %0d",
                        $time, exp_r.next_sp, got.next_sp);
               errors++;
            end
            if (got.outcome !== exp_r.outcome) begin
               $display("%0t: outcome expected %0d actual %0d",
                        $time, exp_r.outcome, got.outcome);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 3000) begin
         $display("stochastic_cell_update_top verification failed");
         $finish;
      end
   end

   // test sequence
   initial begin
      errors = 0; n_writes = 0; n_updates = 0; n_checked = 0;
      hold_left = 0; idle_on = 0;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tuser = 1'b0; req_tdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      load_table(0);
      test_directed();
      idle_on = 1;
      test_random(0, 90);
      test_backpressure();
      test_random(2, 90);
      wait_drained();
      test_random(1, 60);
      idle_on = 0;
      test_random(0, 60);
      wait_drained();
      repeat (30) @(posedge clock);
      $display("covered %0d table writes and %0d cell updates, %0d results checked",
               n_writes, n_updates, n_checked);
      $display("outcomes: colonized %0d empty %0d displaced %0d died %0d survived %0d",
               outcome_seen[1], outcome_seen[2], outcome_seen[3],
               outcome_seen[4], outcome_seen[5]);
      if (errors == 0 && pending_results.size() == 0)
         $display("stochastic_cell_update_top verification clean");
      else
         $display("stochastic_cell_update_top verification failed");
      $finish;
   end

endmodule

// File: filelist.f
rtl/scu_pkg.sv
rtl/scu_ram.sv
rtl/scu_trial.sv
rtl/stochastic_cell_update_top.sv
tb/tb_stochastic_cell_update_top.sv
